// ===== src/siap_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// siap_pkg: shared width helpers for the Stokes I amplitude pipeline
// Derives the radicand and root widths from the sample width so that the top
// level and the root pipeline agree on every bus between them.
// ----------------------------------------------------------------------------
package siap_pkg;

	// re*re + im*im of two magnitudes up to 2^(n-1) stays below 2^(2n)
	function automatic int rad_bits(input int sample_bits);
		return 2 * sample_bits;
	endfunction

	// floor(sqrt(2^(2n-1))) < 2^n, so the root needs n bits
	function automatic int root_bits(input int sample_bits);
		return sample_bits;
	endfunction

endpackage : siap_pkg
`default_nettype wire

// ===== src/siap_root_pipe.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// siap_root_pipe: two-lane pipelined integer square root
// Digit-by-digit binary root, one result bit per register stage, two radicands
// side by side. A word enters on any cycle and leaves from the last register stage.
// ----------------------------------------------------------------------------
module siap_root_pipe #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  logic                                            in_valid,
	input  logic [siap_pkg::rad_bits(SAMPLE_BITS)-1:0]      rad_a,
	input  logic [siap_pkg::rad_bits(SAMPLE_BITS)-1:0]      rad_b,
	output logic                                            out_valid,
	output logic [siap_pkg::root_bits(SAMPLE_BITS)-1:0]     root_a,
	output logic [siap_pkg::root_bits(SAMPLE_BITS)-1:0]     root_b
);
	import siap_pkg::*;

	localparam int RAD_W  = rad_bits(SAMPLE_BITS);
	localparam int ROOT_W = root_bits(SAMPLE_BITS);
	localparam int REM_W  = ROOT_W + 2;
	localparam int STAGES = ROOT_W;

	// per-stage state; index 0 is the unregistered entry point
	logic                vld_s  [STAGES+1];
	logic [RAD_W-1:0]    rad_s  [STAGES][2];
	logic [REM_W-1:0]    rem_s  [STAGES][2];
	logic [ROOT_W-1:0]   root_s [STAGES+1][2];

	// entry
	assign vld_s[0]     = in_valid;
	assign rad_s[0][0]  = rad_a;
	assign rad_s[0][1]  = rad_b;
	assign rem_s[0][0]  = '0;
	assign rem_s[0][1]  = '0;
	assign root_s[0][0] = '0;
	assign root_s[0][1] = '0;

	for (genvar k = 0; k < STAGES; k++) begin : g_stage
		// valid travels with the word
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		for (genvar l = 0; l < 2; l++) begin : g_lane
			logic [REM_W-1:0] rem_sh;
			logic [REM_W-1:0] trial;
			logic             fits;

			// bring down the next two radicand bits, try root*4+1
			assign rem_sh = {rem_s[k][l][REM_W-3:0], rad_s[k][l][RAD_W-1 -: 2]};
			assign trial  = {root_s[k][l], 2'b01};
			assign fits   = (rem_sh >= trial);

			always_ff @(posedge clk) begin
				if (vld_s[k]) begin
					root_s[k+1][l] <= {root_s[k][l][ROOT_W-2:0], fits};
				end
			end

			// remainder and radicand are not needed past the last stage
			if (k < STAGES - 1) begin : g_carry
				always_ff @(posedge clk) begin
					if (vld_s[k]) begin
						rad_s[k+1][l] <= rad_s[k][l] << 2;
						rem_s[k+1][l] <= fits ? (rem_sh - trial) : rem_sh;
					end
				end
			end
		end
	end

	assign out_valid = vld_s[STAGES];
	assign root_a    = root_s[STAGES][0];
	assign root_b    = root_s[STAGES][1];

endmodule : siap_root_pipe
`default_nettype wire

// ===== src/stokes_i_amplitude_pixel.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// stokes_i_amplitude_pixel: Stokes I amplitude of one time-frequency pixel
// Sums the floored magnitudes of the XX and YY complex visibilities.
// ----------------------------------------------------------------------------
// Takes one pixel word on every cycle: busy is always low, so a word is taken
// whenever start is high. Each word gives one result on stokes_i, flagged by a
// one-cycle done pulse. The word passes in order through an absolute-value
// stage, a multiplier stage, an adder stage, the square root, which resolves
// one root bit per pipeline stage, and the output register. Results come out
// in input order and cannot be held off, so the consumer must take every
// done pulse. Nothing is kept between pixels.
// ----------------------------------------------------------------------------
module stokes_i_amplitude_pixel #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [SAMPLE_BITS-1:0] xx_real,
	input  logic signed [SAMPLE_BITS-1:0] xx_imag,
	input  logic signed [SAMPLE_BITS-1:0] yy_real,
	input  logic signed [SAMPLE_BITS-1:0] yy_imag,
	output logic                          done,
	output logic        [SAMPLE_BITS:0]   stokes_i
);
	import siap_pkg::*;

	localparam int RAD_W  = rad_bits(SAMPLE_BITS);
	localparam int ROOT_W = root_bits(SAMPLE_BITS);
	localparam int OUT_W  = SAMPLE_BITS + 1;
	localparam int LAT    = SAMPLE_BITS + 4;

	logic                   accept;
	logic                   vld_s1, vld_s2, vld_s3;
	logic [SAMPLE_BITS-1:0] abs_xr_s1, abs_xi_s1, abs_yr_s1, abs_yi_s1;
	logic [RAD_W-1:0]       sq_xr_s2, sq_xi_s2, sq_yr_s2, sq_yi_s2;
	logic [RAD_W-1:0]       rad_xx_s3, rad_yy_s3;
	logic                   root_vld;
	logic [ROOT_W-1:0]      root_xx, root_yy;
	logic                   done_q;
	logic [OUT_W-1:0]       stokes_i_q;

	// never stalls
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// magnitude of a two's-complement sample; the most negative value maps to
	// 2^(SAMPLE_BITS-1), which still fits unsigned
	function automatic logic [SAMPLE_BITS-1:0] mag(input logic [SAMPLE_BITS-1:0] v);
		return v[SAMPLE_BITS-1] ? (~v + 1'b1) : v;
	endfunction

	// valid bits for the front stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// stage 1: absolute values
	always_ff @(posedge clk) begin
		if (accept) begin
			abs_xr_s1 <= mag(xx_real);
			abs_xi_s1 <= mag(xx_imag);
			abs_yr_s1 <= mag(yy_real);
			abs_yi_s1 <= mag(yy_imag);
		end
	end

	// stage 2: squares
	always_ff @(posedge clk) begin
		if (vld_s1) begin
			sq_xr_s2 <= RAD_W'(abs_xr_s1) * RAD_W'(abs_xr_s1);
			sq_xi_s2 <= RAD_W'(abs_xi_s1) * RAD_W'(abs_xi_s1);
			sq_yr_s2 <= RAD_W'(abs_yr_s1) * RAD_W'(abs_yr_s1);
			sq_yi_s2 <= RAD_W'(abs_yi_s1) * RAD_W'(abs_yi_s1);
		end
	end

	// stage 3: power of each polarization, never above 2^(2*SAMPLE_BITS-1)
	always_ff @(posedge clk) begin
		if (vld_s2) begin
			rad_xx_s3 <= sq_xr_s2 + sq_xi_s2;
			rad_yy_s3 <= sq_yr_s2 + sq_yi_s2;
		end
	end

	// floored roots, one bit per stage
	siap_root_pipe #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_root (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s3),
		.rad_a     (rad_xx_s3),
		.rad_b     (rad_yy_s3),
		.out_valid (root_vld),
		.root_a    (root_xx),
		.root_b    (root_yy)
	);

	// output register: sum of the two magnitudes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= root_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (root_vld) begin
			stokes_i_q <= OUT_W'(root_xx) + OUT_W'(root_yy);
		end
	end

	assign done     = done_q;
	assign stokes_i = stokes_i_q;

`ifndef NO_ASSERTIONS
	// every taken word comes out after the fixed latency
	a_word_out: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##LAT done)
		else $error("accepted word did not produce a result");

	// no result without a matching word taken earlier
	a_no_ghost: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, LAT))
		else $error("result without a matching input word");

	// root pipeline output lines up with the front end
	a_root_align: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 |-> ##SAMPLE_BITS root_vld)
		else $error("root pipeline lost a word");
`endif

endmodule : stokes_i_amplitude_pixel
`default_nettype wire

// ===== sim/stokes_i_amplitude_pixel_test.sv =====
// ----------------------------------------------------------------------------
// stokes_i_amplitude_pixel_test: self-checking bench for the Stokes I pixel
// Feeds pixel words (XX and YY complex samples) through the command port and
// checks every stokes_i result against a table value or an in-bench integer model. The run
// starts with a table of edge-case pixels, then goes on to random pixels
// with random sender gaps, one stretch without gaps, and one full drain.
// ----------------------------------------------------------------------------
module stokes_i_amplitude_pixel_test;

	localparam int SAMPLE_BITS  = 16;
	localparam int OUT_BITS     = SAMPLE_BITS + 1;
	localparam int LATENCY      = SAMPLE_BITS + 4;
	localparam int RESET_CYCLES = 6;
	localparam int RANDOM_WORDS = 1600;
	localparam int IDLE_PCT     = 26;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int SHOW_LIMIT   = 10;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic        [OUT_BITS-1:0]    amp_t;

	// one pixel word; ref_amp is only used when has_ref is set
	typedef struct {
		sample_t xr;
		sample_t xi;
		sample_t yr;
		sample_t yi;
		bit      has_ref;
		amp_t    ref_amp;
	} pixel_t;

	logic    clk      = 1'b0;
	logic    arst_n   = 1'b0;
	logic    start    = 1'b0;
	sample_t xx_real  = '0;
	sample_t xx_imag  = '0;
	sample_t yy_real  = '0;
	sample_t yy_imag  = '0;
	logic    busy;
	logic    done;
	amp_t    stokes_i;

	pixel_t  edge_pixels [$];
	amp_t    stokes_due  [$];
	int      mismatches  = 0;
	int      n_checked   = 0;
	int      cycle_count = 0;

	stokes_i_amplitude_pixel #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.xx_real (xx_real),
		.xx_imag (xx_imag),
		.yy_real (yy_real),
		.yy_imag (yy_imag),
		.done    (done),
		.stokes_i(stokes_i)
	);

	// 12-unit clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// floor of the square root, one result bit per pass
	function automatic longint unsigned floor_root(longint unsigned n);
		longint unsigned root = 0;
		longint unsigned bit_w = 64'd1 << 62;
		while (bit_w > n)
			bit_w >>= 2;
		while (bit_w != 0) begin
			if (n >= root + bit_w) begin
				n    -= root + bit_w;
				root  = (root >> 1) + bit_w;
			end else begin
				root >>= 1;
			end
			bit_w >>= 2;
		end
		return root;
	endfunction

	// floored magnitude of one complex sample; most negative value squares exactly
	function automatic longint unsigned cplx_mag(sample_t re, sample_t im);
		longint          sre = longint'(re);
		longint          sim = longint'(im);
		longint unsigned are = (sre < 0) ? longint'(-sre) : sre;
		longint unsigned aim = (sim < 0) ? longint'(-sim) : sim;
		return floor_root(are * are + aim * aim);
	endfunction

	function automatic amp_t pixel_amplitude(pixel_t p);
		longint unsigned sum = cplx_mag(p.xr, p.xi) + cplx_mag(p.yr, p.yi);
		return amp_t'(sum);
	endfunction

	task automatic add_edge(bit has_ref, int amp, int xr, int xi, int yr, int yi);
		pixel_t p;
		p.xr      = sample_t'(xr);
		p.xi      = sample_t'(xi);
		p.yr      = sample_t'(yr);
		p.yi      = sample_t'(yi);
		p.has_ref = has_ref;
		p.ref_amp = amp_t'(amp);
		edge_pixels.push_back(p);
	endtask

	// random sample: mostly full range, some tiny, some at or near the rails
	function automatic sample_t rand_sample();
		int pick = $urandom_range(0, 99);
		int k;
		if (pick < 60)
			return sample_t'($urandom);
		if (pick < 75)
			return sample_t'(int'($urandom_range(0, 15)) - 8);
		if (pick < 90) begin
			k = $urandom_range(0, 5);
			case (k)
				0: return sample_t'(-32768);
				1: return sample_t'(-32767);
				2: return sample_t'(-1);
				3: return sample_t'(0);
				4: return sample_t'(1);
				default: return sample_t'(32767);
			endcase
		end
		k = $urandom_range(0, 300);
		return ($urandom_range(0, 1) != 0) ? sample_t'(32767 - k) : sample_t'(-32768 + k);
	endfunction

	function automatic pixel_t next_pixel(int idx);
		pixel_t p;
		if (idx < edge_pixels.size())
			return edge_pixels[idx];
		p.xr      = rand_sample();
		p.xi      = rand_sample();
		p.yr      = rand_sample();
		p.yi      = rand_sample();
		p.has_ref = 1'b0;
		p.ref_amp = '0;
		return p;
	endfunction

	task automatic flag_mismatch(string what, amp_t want, amp_t got);
		if (mismatches < SHOW_LIMIT)
			$display("[%0d] %s: expected %0d got %0d", cycle_count, what, want, got);
		mismatches++;
	endtask

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("stokes_i_amplitude_pixel: mismatch");
			$finish;
		end
	end

	// result checker: every done pulse must match the oldest pending amplitude
	always @(posedge clk) begin : check_results
		amp_t want;
		if (arst_n && done) begin
			if (stokes_due.size() == 0) begin
				flag_mismatch("result with nothing pending", '0, stokes_i);
			end else begin
				want = stokes_due.pop_front();
				n_checked++;
				if (stokes_i !== want)
					flag_mismatch("stokes_i", want, stokes_i);
			end
		end
	end

	// stimulus, drain and final verdict
	initial begin : run
		pixel_t cur;
		bit     have_item;
		bit     drained;
		bit     quiet;
		int     n_sent;
		int     total;
		int     drain_at;
		int     n_edge;

		// edge pixels: zero, rails, most negative, tiny and mixed-sign values
		add_edge(1,     0,      0,      0,      0,      0);
		add_edge(1,     1,      1,      0,      0,      0);
		add_edge(1,     1,      0,      0,      0,     -1);
		add_edge(1, 32768, -32768,      0,      0,      0);
		add_edge(1, 32768,      0, -32768,      0,      0);
		add_edge(1, 32768,      0,      0, -32768,      0);
		add_edge(1, 32768,      0,      0,      0, -32768);
		add_edge(1, 32767,  32767,      0,      0,      0);
		add_edge(1, 65534,  32767,      0,      0,  32767);
		add_edge(1, 65536, -32768,      0,      0, -32768);
		add_edge(1, 92680, -32768, -32768, -32768, -32768);
		add_edge(1, 92678,  32767,  32767,  32767,  32767);
		add_edge(1,     2,     -1,     -1,     -1,     -1);
		add_edge(1,    10,      3,      4,     -3,     -4);
		add_edge(1,    10,     -4,      3,      4,     -3);
		add_edge(0,     0, -32768,  32767,  32767, -32768);
		add_edge(0,     0,  32767, -32768, -32767,  32767);
		add_edge(0,     0, -32767, -32767,      1,     -1);
		add_edge(0,     0,  12345, -23456,  -1111,  30000);
		add_edge(0,     0,      2,      2,  -2,      -2);
		add_edge(0,     0,  16384, -16384,  -8192,   8191);

		n_edge    = edge_pixels.size();
		total     = n_edge + RANDOM_WORDS;
		drain_at  = n_edge + 1000;
		n_sent    = 0;
		have_item = 1'b0;
		drained   = 1'b0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		while (n_sent < total || have_item) begin
			@(posedge clk);
			// word taken at this edge
			if (start && !busy) begin
				stokes_due.push_back(cur.has_ref ? cur.ref_amp : pixel_amplitude(cur));
				have_item = 1'b0;
			end
			// one hold-off until every pending result is back
			if (!have_item && n_sent == drain_at && !drained && stokes_due.size() == 0)
				drained = 1'b1;
			if (!have_item && n_sent < total && (n_sent != drain_at || drained)) begin
				cur       = next_pixel(n_sent);
				n_sent++;
				have_item = 1'b1;
			end
			// gap-free stretch in the middle of the random part
			quiet = (n_sent >= n_edge + 500) && (n_sent < n_edge + 800);
			if (have_item && (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
				start   <= 1'b1;
				xx_real <= cur.xr;
				xx_imag <= cur.xi;
				yy_real <= cur.yr;
				yy_imag <= cur.yi;
			end else begin
				start   <= 1'b0;
			end
		end

		// wait for the pipeline to empty, then watch for strays
		while (stokes_due.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 8) @(posedge clk);

		$display("Sent %0d pixel words (%0d edge cases, %0d random), checked %0d results,",
			total, n_edge, RANDOM_WORDS, n_checked);
		$display("with random sender gaps, one gap-free stretch and one full drain; %0d errors.",
			mismatches);
		if (mismatches == 0) begin
			$display("stokes_i_amplitude_pixel: match");
		end else begin
			$display("stokes_i_amplitude_pixel: mismatch");
		end
		$finish;
	end

endmodule
